/* src/psrm_pkg.sv */
// Package for the playback speed ratio monitor.
// Sizes, codes, reset values and the structs passed between the blocks.
// No dependencies.
package psrm_pkg;

    localparam int WINDOW      = 120;
    localparam int MIN_SAMPLES = 30;

    localparam int ADDR_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int TS_W       = 32;
    localparam int RD_W       = 18;
    localparam int GD_W       = 20;
    localparam int RATIO_W    = 16;
    localparam int MARGIN_W   = 8;
    localparam int FRAC_W     = 8;
    localparam int RSUM_W     = RD_W + $clog2(WINDOW);
    localparam int GSUM_W     = GD_W + $clog2(WINDOW);
    localparam int THR_W      = RATIO_W + 1;
    localparam int PROD_W     = THR_W + RSUM_W + 1;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RD_W;

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RATIO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;

    localparam logic                ENABLE_RST  = 1'b1;
    localparam logic [RD_W-1:0]     MAX_GAP_RST = 18'd200000;
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 8'd13;
    localparam logic [RATIO_W-1:0]  RATIO_RST   = 16'd256;

    typedef struct packed {
        logic                enable;
        logic [RD_W-1:0]     max_gap;
        logic [MARGIN_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic                    take;
        logic                    full;
        logic                    clr;
        logic                    restart;
        logic                    chk;
        logic signed [THR_W-1:0] thr;
        logic [CNT_W-1:0]        count;
        logic [RD_W-1:0]         rd;
        logic [GD_W-1:0]         gd;
    } t_stage_a;

    typedef struct packed {
        logic                    valid;
        logic                    take;
        logic                    chk;
        logic                    restart;
        logic signed [THR_W-1:0] thr;
        logic [CNT_W-1:0]        count;
    } t_stage_b;

    typedef struct packed {
        logic             alarm;
        logic [CNT_W-1:0] count;
        logic             taken;
    } t_result;

endpackage

/* src/psrm_ring_ram.sv */
// Generic synchronous RAM, one write and one read port, read-first.
// Read data registered. No dependencies.
module psrm_ring_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 120
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/psrm_window_ctrl.sv */
// Window control: timestamp, sample count, ring pointer, expected ratio.
// Decodes each transaction and drives the ring RAM ports. Uses psrm_pkg.
module psrm_window_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_valid,
    input  logic [psrm_pkg::KIND_W-1:0]     i_kind,
    input  logic [psrm_pkg::TS_W-1:0]       i_real_time_us,
    input  logic [psrm_pkg::GD_W-1:0]       i_game_delta_us,
    input  logic                            i_player_dead,
    input  logic                            i_paused,
    input  logic [psrm_pkg::RATIO_W-1:0]    i_new_ratio_q8,
    input  psrm_pkg::t_cfg                  i_cfg,
    output psrm_pkg::t_stage_a              o_stage,
    output logic                            o_ram_we,
    output logic [psrm_pkg::ADDR_W-1:0]     o_ram_waddr,
    output logic [psrm_pkg::RD_W-1:0]       o_ram_wrd,
    output logic [psrm_pkg::GD_W-1:0]       o_ram_wgd,
    output logic                            o_ram_re,
    output logic [psrm_pkg::ADDR_W-1:0]     o_ram_raddr
);
    import psrm_pkg::*;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_oldest, n_oldest;
    logic [TS_W-1:0]    r_last_ts, n_last_ts;
    logic               r_ts_valid, n_ts_valid;
    logic [RATIO_W-1:0] r_ratio, n_ratio;
    t_stage_a           r_stage, n_stage;

    logic              fire, tick, take, full;
    logic [TS_W-1:0]   gap;
    logic [ADDR_W:0]   slot_sum, slot_wrap;
    logic [ADDR_W-1:0] slot, oldest_inc;

    assign fire = i_valid & i_adv;
    assign gap  = i_real_time_us - r_last_ts;
    assign tick = (i_kind == KIND_TICK) && i_cfg.enable && !i_player_dead && !i_paused;
    assign take = tick && r_ts_valid && (gap <= {{(TS_W-RD_W){1'b0}}, i_cfg.max_gap});
    assign full = (r_count == CNT_W'(WINDOW));

    assign slot_sum   = (ADDR_W+1)'(r_oldest) + (ADDR_W+1)'(r_count);
    assign slot_wrap  = (slot_sum >= (ADDR_W+1)'(WINDOW)) ? slot_sum - (ADDR_W+1)'(WINDOW)
                                                           : slot_sum;
    assign slot       = full ? r_oldest : slot_wrap[ADDR_W-1:0];
    assign oldest_inc = (r_oldest == ADDR_W'(WINDOW - 1)) ? '0 : r_oldest + 1'b1;

    always_comb begin
        n_count    = r_count;
        n_oldest   = r_oldest;
        n_last_ts  = r_last_ts;
        n_ts_valid = r_ts_valid;
        n_ratio    = r_ratio;
        if (fire) begin
            case (i_kind)
                KIND_TICK: begin
                    if (tick) begin
                        n_last_ts  = i_real_time_us;
                        n_ts_valid = 1'b1;
                        if (take) begin
                            if (full) begin
                                n_oldest = oldest_inc;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                end
                KIND_RATIO: begin
                    n_ratio  = i_new_ratio_q8;
                    n_count  = '0;
                    n_oldest = '0;
                end
                KIND_RESTART: begin
                    n_count    = '0;
                    n_oldest   = '0;
                    n_ts_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_stage.valid   = i_valid;
        n_stage.take    = take;
        n_stage.full    = full;
        n_stage.clr     = (i_kind == KIND_RATIO) || (i_kind == KIND_RESTART);
        n_stage.restart = (i_kind == KIND_RESTART);
        n_stage.chk     = take && (32'(n_count) >= 32'(MIN_SAMPLES));
        n_stage.thr     = $signed({1'b0, r_ratio})
                        - $signed({{(THR_W-MARGIN_W){1'b0}}, i_cfg.margin});
        n_stage.count   = n_count;
        n_stage.rd      = gap[RD_W-1:0];
        n_stage.gd      = i_game_delta_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_oldest   <= '0;
            r_last_ts  <= '0;
            r_ts_valid <= 1'b0;
            r_ratio    <= RATIO_RST;
        end else begin
            r_count    <= n_count;
            r_oldest   <= n_oldest;
            r_last_ts  <= n_last_ts;
            r_ts_valid <= n_ts_valid;
            r_ratio    <= n_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage     = r_stage;
    assign o_ram_we    = fire & take;
    assign o_ram_waddr = slot;
    assign o_ram_wrd   = gap[RD_W-1:0];
    assign o_ram_wgd   = i_game_delta_us;
    assign o_ram_re    = fire;
    assign o_ram_raddr = r_oldest;

endmodule

/* src/psrm_sum_check.sv */
// Running window sums and the sticky slowdown alarm.
// Sum update, then the Q8.8 cross-multiplied compare. Uses psrm_pkg.
module psrm_sum_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  psrm_pkg::t_stage_a          i_stage,
    input  logic [psrm_pkg::RD_W-1:0]   i_old_rd,
    input  logic [psrm_pkg::GD_W-1:0]   i_old_gd,
    output psrm_pkg::t_result           o_result,
    output logic                        o_valid
);
    import psrm_pkg::*;

    logic [RSUM_W-1:0] r_rsum, n_rsum;
    logic [GSUM_W-1:0] r_gsum, n_gsum;
    logic              r_alarm, n_alarm;
    t_stage_b          r_sb, n_sb;

    logic [RD_W-1:0]          old_rd;
    logic [GD_W-1:0]          old_gd;
    logic signed [PROD_W-1:0] rhs, lhs;
    logic                     hit;

    assign old_rd = i_stage.full ? i_old_rd : '0;
    assign old_gd = i_stage.full ? i_old_gd : '0;
    assign n_rsum = r_rsum + RSUM_W'(i_stage.rd) - RSUM_W'(old_rd);
    assign n_gsum = r_gsum + GSUM_W'(i_stage.gd) - GSUM_W'(old_gd);

    always_comb begin
        n_sb.valid   = i_stage.valid;
        n_sb.take    = i_stage.take;
        n_sb.chk     = i_stage.chk;
        n_sb.restart = i_stage.restart;
        n_sb.thr     = i_stage.thr;
        n_sb.count   = i_stage.count;
    end

    assign rhs = r_sb.thr * $signed({1'b0, r_rsum});
    assign lhs = $signed({{(PROD_W-GSUM_W-FRAC_W){1'b0}}, r_gsum, {FRAC_W{1'b0}}});
    assign hit = r_sb.chk && (r_gsum != '0) && (lhs < rhs);
    assign n_alarm = r_sb.restart ? 1'b0 : (r_alarm | hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsum     <= '0;
            r_gsum     <= '0;
            r_alarm    <= 1'b0;
            r_sb.valid <= 1'b0;
        end else if (i_adv) begin
            r_sb <= n_sb;
            if (i_stage.valid) begin
                if (i_stage.clr) begin
                    r_rsum <= '0;
                    r_gsum <= '0;
                end else if (i_stage.take) begin
                    r_rsum <= n_rsum;
                    r_gsum <= n_gsum;
                end
            end
            if (r_sb.valid) begin
                r_alarm <= n_alarm;
            end
        end
    end

    assign o_result.alarm = n_alarm;
    assign o_result.count = r_sb.count;
    assign o_result.taken = r_sb.take;
    assign o_valid        = r_sb.valid;

endmodule

/* src/playback_speed_ratio_monitor.sv */
// Playback speed ratio monitor, top level: config registers, ring RAMs,
// output register. Uses psrm_pkg, psrm_ring_ram, psrm_window_ctrl, psrm_sum_check.
//
// Takes one transaction per clock while not stalled and returns one result per
// transaction, in order, after the window control stage, the sum stage and the
// output register. The block only stalls when the output register is full and
// not taken. Each accepted transaction reads the oldest sample from the ring RAMs
// and, when the sample is taken, writes the new one (read-first). The running sums
// and the 17x26-bit threshold multiply each take one stage.
// Ring contents need no clearing; no entry is used before it is written.
module playback_speed_ratio_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [psrm_pkg::KIND_W-1:0]         i_kind,
    input  logic [psrm_pkg::TS_W-1:0]           i_real_time_us,
    input  logic [psrm_pkg::GD_W-1:0]           i_game_delta_us,
    input  logic                                i_player_dead,
    input  logic                                i_paused,
    input  logic [psrm_pkg::RATIO_W-1:0]        i_new_ratio_q8,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_slowdown_detected,
    output logic [psrm_pkg::CNT_W-1:0]          o_samples_held,
    output logic                                o_sample_taken,
    input  logic                                i_cfg_we,
    input  logic [psrm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [psrm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import psrm_pkg::*;

    t_cfg     r_cfg;
    logic     adv;
    t_stage_a w_stage;
    t_result  w_result, r_result;
    logic     w_res_valid, r_out_valid;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [RD_W-1:0]   ram_wrd, ram_rrd;
    logic [GD_W-1:0]   ram_wgd, ram_rgd;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= ENABLE_RST;
            r_cfg.max_gap <= MAX_GAP_RST;
            r_cfg.margin  <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:  r_cfg.enable  <= i_cfg_data[0];
                CFG_MAX_GAP: r_cfg.max_gap <= i_cfg_data[RD_W-1:0];
                CFG_MARGIN:  r_cfg.margin  <= i_cfg_data[MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    psrm_window_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_in_valid),
        .i_kind          (i_kind),
        .i_real_time_us  (i_real_time_us),
        .i_game_delta_us (i_game_delta_us),
        .i_player_dead   (i_player_dead),
        .i_paused        (i_paused),
        .i_new_ratio_q8  (i_new_ratio_q8),
        .i_cfg           (r_cfg),
        .o_stage         (w_stage),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wrd       (ram_wrd),
        .o_ram_wgd       (ram_wgd),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr)
    );

    psrm_ring_ram #(.WIDTH(RD_W), .DEPTH(WINDOW)) u_real_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wrd),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rrd)
    );

    psrm_ring_ram #(.WIDTH(GD_W), .DEPTH(WINDOW)) u_game_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wgd),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rgd)
    );

    psrm_sum_check u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_stage  (w_stage),
        .i_old_rd (ram_rrd),
        .i_old_gd (ram_rgd),
        .o_result (w_result),
        .o_valid  (w_res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_res_valid;
            r_result    <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_slowdown_detected = r_result.alarm;
    assign o_samples_held      = r_result.count;
    assign o_sample_taken      = r_result.taken;

    a_taken_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sample_taken |-> o_samples_held != '0)
        else $error("sample taken with empty window");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage.valid && w_stage.take && w_stage.full |-> w_stage.count == CNT_W'(WINDOW))
        else $error("full-window sample changed the count");

    a_take_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage.valid && w_stage.take |-> !w_stage.clr)
        else $error("sample and window clear in one transaction");

endmodule
